// ===== rtl/core/ncs_pkg.sv =====
`default_nettype none

package ncs_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int DEPTH_W = 5;
	localparam int ARGC_W = 4;

	// if and elseif take the command word and exactly one argument.
	localparam logic [ARGC_W-1:0] ARGS_NEEDED = 4'd2;

	typedef enum logic [1:0] {
		CMD_IF     = 2'd0,
		CMD_ELSEIF = 2'd1,
		CMD_ELSE   = 2'd2,
		CMD_ENDIF  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TOO_DEEP = 2'd1,
		ST_ARGS     = 2'd2,
		ST_NO_IF    = 2'd3
	} status_t;

	// One open conditional level.
	typedef struct packed {
		logic inh;
		logic tak;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/nested_condition_stack.sv =====
`default_nettype none

// Channel  | Handshake             | Payload
// command  | cmd_valid, cmd_stall  | cmd, arg_count, test_true
// result   | res_valid, res_stall  | status, enabled, depth
//
// One command per cycle while the result is not stalled, through the input
// register and the result register. The top level lives in flip-flops and the
// level below it in a prefetch register, so each command touches the stack
// memory at most once: a write on if, a read on endif. After reset the depth is
// zero and the enable is one; stack entries need no clearing. A stalled result
// holds the input register, which then stalls the command channel.

module nested_condition_stack #(
	parameter int STACK_DEPTH = ncs_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire ncs_pkg::cmd_t                 cmd,
	input  wire logic [ncs_pkg::ARGC_W-1:0]    arg_count,
	input  wire logic                          test_true,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output ncs_pkg::status_t                   status,
	output logic                               enabled,
	output logic [ncs_pkg::DEPTH_W-1:0]        depth
);
	import ncs_pkg::*;

	localparam int LW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [LW-1:0] LVL_FULL = LW'(STACK_DEPTH - 1);

	// Input register.
	logic              vld_s1;
	cmd_t              cmd_s1;
	logic [ARGC_W-1:0] argc_s1;
	logic              test_s1;

	// Stack state.
	logic [LW-1:0] lvl_q;
	entry_t        top_q;
	entry_t        below_q;
	entry_t        stack_mem [STACK_DEPTH];

	logic          adv;
	logic          fire;
	logic          en_cur;
	logic          n_en;
	logic [LW-1:0] n_lvl;
	entry_t        n_top;
	status_t       st_d;
	logic          do_push;
	logic          do_pop;
	logic          has_below2;
	logic [LW-1:0] wr_idx;
	logic [LW-1:0] rd_idx;

	assign adv = !res_valid || !res_stall;
	assign fire = vld_s1 && adv;
	assign cmd_stall = vld_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			vld_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!cmd_stall && cmd_valid) begin
			cmd_s1 <= cmd;
			argc_s1 <= arg_count;
			test_s1 <= test_true;
		end
	end

	// At depth zero the enable is one; otherwise it follows the top level.
	assign en_cur = (lvl_q == '0) || (top_q.inh && top_q.tak);
	assign n_en = (n_lvl == '0) || (n_top.inh && n_top.tak);

	always_comb begin
		n_lvl = lvl_q;
		n_top = top_q;
		st_d = ST_OK;
		do_push = 1'b0;
		do_pop = 1'b0;
		if (cmd_s1 == CMD_IF) begin
			if (lvl_q == LVL_FULL) begin
				st_d = ST_TOO_DEEP;
			end else if (argc_s1 != ARGS_NEEDED) begin
				st_d = ST_ARGS;
			end else begin
				do_push = 1'b1;
				n_top.inh = en_cur;
				n_top.tak = test_s1;
				n_lvl = lvl_q + LW'(1);
			end
		end else if (lvl_q == '0) begin
			st_d = ST_NO_IF;
		end else begin
			unique case (cmd_s1)
				CMD_ELSEIF: begin
					if (argc_s1 != ARGS_NEEDED) begin
						st_d = ST_ARGS;
					end else if (top_q.inh && top_q.tak) begin
						// An earlier branch ran: the rest of this level stays off.
						n_top.inh = 1'b0;
						n_top.tak = 1'b0;
					end else if (top_q.inh) begin
						n_top.tak = test_s1;
					end
				end
				CMD_ELSE: begin
					n_top.tak = !top_q.tak;
				end
				CMD_ENDIF: begin
					do_pop = 1'b1;
					n_top = below_q;
					n_lvl = lvl_q - LW'(1);
				end
				default: begin
				end
			endcase
		end
	end

	assign has_below2 = (LW + 2)'(lvl_q) >= (LW + 2)'(3);
	assign wr_idx = lvl_q - LW'(1);
	assign rd_idx = LW'((LW + 2)'(lvl_q) - (LW + 2)'(3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else if (fire) begin
			lvl_q <= n_lvl;
		end
	end

	// The old top goes to memory on a push; a pop refills the level below
	// the new top from memory.
	always_ff @(posedge clk) begin
		if (fire) begin
			top_q <= n_top;
			if (do_push && lvl_q != '0) begin
				stack_mem[wr_idx] <= top_q;
				below_q <= top_q;
			end else if (do_pop && has_below2) begin
				below_q <= stack_mem[rd_idx];
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (adv) begin
			res_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status <= st_d;
			enabled <= n_en;
			depth <= DEPTH_W'(n_lvl);
		end
	end

`ifndef SYNTHESIS
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1 == CMD_IF && lvl_q != LVL_FULL && argc_s1 == ARGS_NEEDED)
		|=> lvl_q == $past(lvl_q) + LW'(1))
		else $error("accepted if did not push a level");

	// The top register holds nothing meaningful while no level is open.
	a_error_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && st_d != ST_OK) |=> ($stable(lvl_q) && (lvl_q == '0 || $stable(top_q))))
		else $error("failed command changed the stack");

	a_no_if_status: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd_s1 != CMD_IF && lvl_q == '0) |=> (res_valid && status == ST_NO_IF))
		else $error("command at depth zero not reported as no open if");

	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && do_pop) |=> (lvl_q == $past(lvl_q) - LW'(1) && enabled == $past(n_en)))
		else $error("endif did not restore the level below");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;
	import ncs_pkg::*;

	localparam int STACK_LEVELS = STACK_DEPTH_DEF;

	typedef struct packed {
		status_t          st;
		logic             en;
		logic [DEPTH_W-1:0] dep;
	} cond_result_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_stall;
	cmd_t                 cmd = CMD_IF;
	logic [ARGC_W-1:0]    arg_count = '0;
	logic                 test_true = 1'b0;
	logic                 res_valid;
	logic                 res_stall = 1'b0;
	status_t              status;
	logic                 enabled;
	logic [DEPTH_W-1:0]   depth;

	// Shadow copy of the condition stack, updated as each transaction is accepted.
	logic inh_stack [STACK_LEVELS];
	logic tak_stack [STACK_LEVELS];
	int   open_levels = 0;
	logic cur_enable = 1'b1;

	cond_result_t pending_results[$];
	int errors = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	nested_condition_stack DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.arg_count (arg_count),
		.test_true (test_true),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.status    (status),
		.enabled   (enabled),
		.depth     (depth)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic cond_result_t predict_condition(cmd_t c, logic [ARGC_W-1:0] argc,
			logic t);
		cond_result_t r;
		int top;
		r.st = ST_OK;
		top = open_levels - 1;
		if (c == CMD_IF) begin
			if (open_levels + 1 >= STACK_LEVELS) begin
				r.st = ST_TOO_DEEP;
			end else if (argc != ARGS_NEEDED) begin
				r.st = ST_ARGS;
			end else begin
				inh_stack[open_levels] = cur_enable;
				tak_stack[open_levels] = t;
				cur_enable = cur_enable & t;
				open_levels++;
			end
		end else if (open_levels == 0) begin
			r.st = ST_NO_IF;
		end else if (c == CMD_ELSEIF) begin
			if (argc != ARGS_NEEDED) begin
				r.st = ST_ARGS;
			end else if (!inh_stack[top]) begin
				cur_enable = 1'b0;
			end else if (tak_stack[top]) begin
				// An earlier branch ran, so the rest of this level stays off for good.
				inh_stack[top] = 1'b0;
				tak_stack[top] = 1'b0;
				cur_enable = 1'b0;
			end else begin
				tak_stack[top] = t;
				cur_enable = inh_stack[top] & t;
			end
		end else if (c == CMD_ELSE) begin
			tak_stack[top] = ~tak_stack[top];
			cur_enable = inh_stack[top] & tak_stack[top];
		end else begin
			open_levels = top;
			if (open_levels != 0)
				cur_enable = inh_stack[open_levels - 1] & tak_stack[open_levels - 1];
			else
				cur_enable = 1'b1;
		end
		r.en = cur_enable;
		r.dep = open_levels[DEPTH_W-1:0];
		return r;
	endfunction

	task automatic send_cmd(cmd_t c, logic [ARGC_W-1:0] argc, logic t);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		arg_count <= argc;
		test_true <= t;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		pending_results.push_back(predict_condition(c, argc, t));
	endtask

	task automatic wait_for_results();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		res_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
	end

	always @(posedge clk) begin
		cond_result_t exp_r;
		if (res_valid && !res_stall) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (status !== exp_r.st) begin
					$error("status: expected %0d, actual %0d", exp_r.st, status);
					errors++;
				end
				if (enabled !== exp_r.en) begin
					$error("enabled: expected %0d, actual %0d", exp_r.en, enabled);
					errors++;
				end
				if (depth !== exp_r.dep) begin
					$error("depth: expected %0d, actual %0d", exp_r.dep, depth);
					errors++;
				end
			end
		end
	end

	task automatic test_directed_commands();
		// Commands with no open level, then argument count errors on if.
		send_cmd(CMD_ELSEIF, 4'd2, 1'b1);
		send_cmd(CMD_ELSE, 4'd15, 1'b1);
		send_cmd(CMD_ENDIF, 4'd0, 1'b0);
		send_cmd(CMD_IF, 4'd0, 1'b1);
		send_cmd(CMD_IF, 4'd15, 1'b1);
		// Taken if, then elseif after a taken branch, then elseif on a dead level.
		send_cmd(CMD_IF, 4'd2, 1'b1);
		send_cmd(CMD_ELSEIF, 4'd2, 1'b1);
		send_cmd(CMD_ELSEIF, 4'd2, 1'b1);
		send_cmd(CMD_ELSE, 4'd2, 1'b0);
		send_cmd(CMD_ENDIF, 4'd2, 1'b1);
		// Nesting under a disabled branch.
		send_cmd(CMD_IF, 4'd2, 1'b0);
		send_cmd(CMD_IF, 4'd2, 1'b1);
		send_cmd(CMD_ELSE, 4'd5, 1'b0);
		send_cmd(CMD_ELSEIF, 4'd3, 1'b1);
		send_cmd(CMD_ELSEIF, 4'd2, 1'b1);
		send_cmd(CMD_ENDIF, 4'd8, 1'b0);
		// Untaken level picks up a true elseif, then else flips it off.
		send_cmd(CMD_ELSEIF, 4'd2, 1'b1);
		send_cmd(CMD_ELSE, 4'd1, 1'b1);
		send_cmd(CMD_ELSE, 4'd7, 1'b0);
		send_cmd(CMD_ENDIF, 4'd2, 1'b1);
		send_cmd(CMD_ENDIF, 4'd2, 1'b1);
	endtask

	task automatic test_stack_limit();
		int i;
		for (i = 0; i < STACK_LEVELS - 1; i++)
			send_cmd(CMD_IF, 4'd2, i % 7 != 3);
		// A full stack reports too deep even with a bad argument count.
		send_cmd(CMD_IF, 4'd2, 1'b1);
		send_cmd(CMD_IF, 4'd9, 1'b0);
		send_cmd(CMD_ELSEIF, 4'd2, 1'b1);
		send_cmd(CMD_ELSE, 4'd0, 1'b0);
		for (i = 0; i < STACK_LEVELS - 1; i++)
			send_cmd(CMD_ENDIF, 4'($urandom_range(15)), 1'($urandom_range(1)));
		send_cmd(CMD_ENDIF, 4'd2, 1'b0);
	endtask

	task automatic test_random_traffic(int n, int idle_pct, int stall_prob);
		int sent;
		int r;
		int p_if;
		logic [ARGC_W-1:0] argc;
		sent = 0;
		send_idle_pct = idle_pct;
		stall_pct = stall_prob;
		while (sent < n) begin
			r = $urandom_range(99);
			if (r < 6) begin
				send_cmd(cmd_t'($urandom_range(3)), 4'($urandom_range(15)),
					1'($urandom_range(1)));
				sent++;
			end else if (r < 7) begin
				// Dive to the top of the stack and hit the limit.
				while (open_levels + 1 < STACK_LEVELS) begin
					send_cmd(CMD_IF, ARGS_NEEDED, 1'($urandom_range(3) != 0));
					sent++;
				end
				send_cmd(CMD_IF, 4'($urandom_range(15)), 1'($urandom_range(1)));
				sent++;
			end else begin
				p_if = open_levels < 3 ? 55 : (open_levels > 20 ? 20 : 32);
				r = $urandom_range(99);
				argc = ($urandom_range(19) == 0) ? 4'($urandom_range(15)) : ARGS_NEEDED;
				if (r < p_if || open_levels == 0)
					send_cmd(CMD_IF, argc, 1'($urandom_range(1)));
				else if (r < p_if + 25)
					send_cmd(CMD_ELSEIF, argc, 1'($urandom_range(1)));
				else if (r < p_if + 40)
					send_cmd(CMD_ELSE, 4'($urandom_range(15)), 1'($urandom_range(1)));
				else
					send_cmd(CMD_ENDIF, 4'($urandom_range(15)), 1'($urandom_range(1)));
				sent++;
			end
		end
		wait_for_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_commands();
		wait_for_results();
		test_stack_limit();
		wait_for_results();
		test_random_traffic(400, 0, 0);
		test_random_traffic(400, 60, 0);
		test_random_traffic(400, 0, 60);
		test_random_traffic(400, 34, 34);

		stall_pct = 0;
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
